// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each check is clocked on clk and
// held off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true at a clock edge out of reset.
`define ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== rtl/ldf_pkg.sv =====
// ----------------------------------------------------------------------------
// ldf_pkg
// Types, codes and reset values shared by the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ldf_pkg;

  localparam int LEN_W = 25;
  localparam int DIM_W = 16;
  localparam int CFG_W = 25;
  localparam int CFG_IDX_W = 2;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [LEN_W-1:0] MAX_LEN_RST    = 25'd16777216;
  localparam logic [DIM_W-1:0] MAX_WIDTH_RST  = 16'd7680;
  localparam logic [DIM_W-1:0] MAX_HEIGHT_RST = 16'd4320;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_HEIGHT = 2'd2;

  localparam logic OP_BYTE      = 1'b0;
  localparam logic OP_RECONNECT = 1'b1;

  typedef enum logic [1:0] {
    ST_DATA    = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_BAD_DIM = 2'd2,
    ST_ABORT   = 2'd3
  } status_t;

  typedef struct packed {
    logic [LEN_W-1:0] max_payload_len;
    logic [DIM_W-1:0] max_width;
    logic [DIM_W-1:0] max_height;
  } cfg_t;

  typedef struct packed {
    status_t          status;
    logic [7:0]       payload_byte;
    logic             is_last;
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
  } result_t;

endpackage

// ===== rtl/ldf_front.sv =====
// ----------------------------------------------------------------------------
// ldf_front
// Header collection, header checks and payload tracking; emits at most one
// result record per accepted transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ldf_front
  import ldf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       operation,
  input  logic [7:0] stream_byte,
  input  cfg_t       cfg,
  output logic       res_valid,
  output result_t    res
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DROPPED = 2'd2
  } phase_t;

  phase_t           phase, phase_next;
  logic [2:0]       hdr_idx, hdr_idx_next;
  logic [31:0]      len_acc, len_acc_next;
  logic [DIM_W-1:0] wid_acc, wid_acc_next;
  logic [DIM_W-1:0] hgt_acc, hgt_acc_next;
  logic [LEN_W-1:0] bytes_left, bytes_left_next;

  logic [DIM_W-1:0] hgt_full;
  logic             len_bad;
  logic             dim_bad;
  logic             last;
  logic             do_restart;

  // height as it stands once the eighth header byte lands
  assign hgt_full = {hgt_acc[15:8] | stream_byte, hgt_acc[7:0]};
  assign len_bad  = (len_acc == 32'd0) || (len_acc > {7'd0, cfg.max_payload_len});
  assign dim_bad  = (wid_acc == '0) || (hgt_full == '0) ||
                    (wid_acc > cfg.max_width) || (hgt_full > cfg.max_height);
  assign last     = (bytes_left <= {{(LEN_W-1){1'b0}}, 1'b1});

  always_comb begin
    phase_next      = phase;
    hdr_idx_next    = hdr_idx;
    len_acc_next    = len_acc;
    wid_acc_next    = wid_acc;
    hgt_acc_next    = hgt_acc;
    bytes_left_next = bytes_left;
    do_restart      = 1'b0;
    res_valid       = 1'b0;
    res.status       = ST_DATA;
    res.payload_byte = 8'd0;
    res.is_last      = 1'b0;
    res.frame_width  = wid_acc;
    res.frame_height = hgt_acc;

    if (in_valid) begin
      if (operation == OP_RECONNECT) begin
        if (phase == PH_PAYLOAD) begin
          res_valid  = 1'b1;
          res.status = ST_ABORT;
        end
        do_restart = 1'b1;
      end else begin
        case (phase)
          PH_DROPPED: begin
          end
          PH_PAYLOAD: begin
            res_valid        = 1'b1;
            res.payload_byte = stream_byte;
            res.is_last      = last;
            if (last) begin
              do_restart = 1'b1;
            end else begin
              bytes_left_next = bytes_left - {{(LEN_W-1){1'b0}}, 1'b1};
            end
          end
          default: begin
            if (hdr_idx < 3'd4) begin
              len_acc_next[{hdr_idx[1:0], 3'b000} +: 8] =
                len_acc[{hdr_idx[1:0], 3'b000} +: 8] | stream_byte;
            end else if (hdr_idx < 3'd6) begin
              wid_acc_next[{hdr_idx[0], 3'b000} +: 8] =
                wid_acc[{hdr_idx[0], 3'b000} +: 8] | stream_byte;
            end else begin
              hgt_acc_next[{hdr_idx[0], 3'b000} +: 8] =
                hgt_acc[{hdr_idx[0], 3'b000} +: 8] | stream_byte;
            end
            if (hdr_idx != 3'd7) begin
              hdr_idx_next = hdr_idx + 3'd1;
            end else begin
              hdr_idx_next     = 3'd0;
              res.frame_height = hgt_full;
              if (len_bad) begin
                res_valid  = 1'b1;
                res.status = ST_BAD_LEN;
                phase_next = PH_DROPPED;
              end else if (dim_bad) begin
                res_valid  = 1'b1;
                res.status = ST_BAD_DIM;
                phase_next = PH_DROPPED;
              end else begin
                bytes_left_next = len_acc[LEN_W-1:0];
                phase_next      = PH_PAYLOAD;
              end
            end
          end
        endcase
      end
    end

    if (do_restart) begin
      phase_next      = PH_HEADER;
      hdr_idx_next    = 3'd0;
      len_acc_next    = 32'd0;
      wid_acc_next    = '0;
      hgt_acc_next    = '0;
      bytes_left_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      hdr_idx    <= 3'd0;
      len_acc    <= 32'd0;
      wid_acc    <= '0;
      hgt_acc    <= '0;
      bytes_left <= '0;
    end else begin
      phase      <= phase_next;
      hdr_idx    <= hdr_idx_next;
      len_acc    <= len_acc_next;
      wid_acc    <= wid_acc_next;
      hgt_acc    <= hgt_acc_next;
      bytes_left <= bytes_left_next;
    end
  end

endmodule

// ===== rtl/ldf_queue.sv =====
// ----------------------------------------------------------------------------
// ldf_queue
// Small result queue between the parser and the result port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ldf_queue
  import ldf_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  result_t wr_data,
  input  logic    rd_en,
  output result_t rd_data,
  output logic    full,
  output logic    empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  result_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/length_prefixed_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer
// Byte-stream deframer for frames with an 8-byte length/width/height header.
// ----------------------------------------------------------------------------
// Input channel: a transaction is taken when push is high and full is low.
//   operation 0 carries stream_byte; operation 1 signals a link reconnect.
// Result channel: while empty is low the oldest result sits on status,
//   payload_byte, is_last, frame_width and frame_height; pop takes it.
// Configuration: cfg_write with cfg_index 0/1/2 sets max_payload_len,
//   max_width, max_height; change them only while the block is idle.
// Header bytes and good headers give no result; a bad header gives one
//   error result and bytes are then dropped until a reconnect. Each payload
//   byte gives one result, and a reconnect mid-payload gives an abort result.
// Each result is written into the result queue and reaches the result ports
//   once older results are popped. Throughput: one input transaction per cycle,
//   sustained while results are popped as fast as they are produced.
// When the receiver stalls, the result queue (QUEUE_DEPTH entries) fills and
//   full rises; input transactions that give no result are also held off then.
// Reset (rst, synchronous): queue emptied, header search restarts, limits
//   return to 16777216 / 7680 / 4320.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module length_prefixed_frame_deframer
  import ldf_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic                 operation,
  input  logic [7:0]           stream_byte,
  output logic                 empty,
  input  logic                 pop,
  output logic [1:0]           status,
  output logic [7:0]           payload_byte,
  output logic                 is_last,
  output logic [DIM_W-1:0]     frame_width,
  output logic [DIM_W-1:0]     frame_height,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

`include "assert_macros.svh"

  cfg_t    cfg;
  logic    in_valid;
  logic    res_valid;
  result_t res;
  result_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_payload_len <= MAX_LEN_RST;
      cfg.max_width       <= MAX_WIDTH_RST;
      cfg.max_height      <= MAX_HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAX_LEN:    cfg.max_payload_len <= cfg_data[LEN_W-1:0];
        REG_MAX_WIDTH:  cfg.max_width       <= cfg_data[DIM_W-1:0];
        REG_MAX_HEIGHT: cfg.max_height      <= cfg_data[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_valid = push && !full;

  ldf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .operation   (operation),
    .stream_byte (stream_byte),
    .cfg         (cfg),
    .res_valid   (res_valid),
    .res         (res)
  );

  ldf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_valid),
    .wr_data (res),
    .rd_en   (pop),
    .rd_data (head),
    .full    (full),
    .empty   (empty)
  );

  assign status       = head.status;
  assign payload_byte = head.payload_byte;
  assign is_last      = head.is_last;
  assign frame_width  = head.frame_width;
  assign frame_height = head.frame_height;

  `ASSERT_NEVER(a_full_and_empty, full && empty, "queue reports full and empty together")
  `ASSERT_NEVER(a_write_when_full, res_valid && full, "result produced while queue is full")
  `ASSERT_CLK(a_pop_frees_slot, (pop && !empty && !push) |=> !full, "pop did not free a slot")
  `ASSERT_CLK(a_error_fields_clear, (res_valid && res.status != ST_DATA) |-> (res.payload_byte == 8'd0 && !res.is_last), "non-data result carries payload")

endmodule

// ===== tb/length_prefixed_frame_deframer_test.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_test
// Self-checking bench for the frame deframer: byte and reconnect transactions
// go in through a driver with random gaps, a predictor works out the result
// stream, and a monitor with random pop stalls checks every result field.
// Limits are rewritten between phases, the extremes among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module length_prefixed_frame_deframer_test;
  import ldf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 220;
  localparam int DRAIN_CYCLES = 8;

  typedef enum logic [1:0] {
    SEEK_HEADER,
    IN_PAYLOAD,
    DROPPING
  } deframe_phase_t;

  typedef struct {
    logic       op;
    logic [7:0] data;
  } stream_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic operation = OP_BYTE;
  logic [7:0] stream_byte = 8'h00;
  logic empty;
  logic pop = 1'b0;
  logic [1:0] status;
  logic [7:0] payload_byte;
  logic is_last;
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MAX_LEN;
  logic [CFG_W-1:0] cfg_data = '0;

  stream_item_t pending_items[$];
  result_t expected_results[$];
  result_t predicted;
  result_t oldest;
  bit produced;
  bit no_idle = 1'b0;
  int cycle = 0;
  int mismatch_count = 0;

  // predictor state
  cfg_t limits;
  deframe_phase_t dphase;
  logic [2:0] hdr_count;
  logic [31:0] len_acc;
  logic [15:0] wid_acc;
  logic [15:0] hgt_acc;
  logic [24:0] remaining;

  length_prefixed_frame_deframer dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .operation(operation),
    .stream_byte(stream_byte),
    .empty(empty),
    .pop(pop),
    .status(status),
    .payload_byte(payload_byte),
    .is_last(is_last),
    .frame_width(frame_width),
    .frame_height(frame_height),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(0, 99) < 7);
  endfunction

  task automatic restart_search();
    dphase = SEEK_HEADER;
    hdr_count = '0;
    len_acc = '0;
    wid_acc = '0;
    hgt_acc = '0;
    remaining = '0;
  endtask

  task automatic make_result(input status_t st, input logic [7:0] b, input logic last,
                             output result_t r);
    r.status = st;
    r.payload_byte = b;
    r.is_last = last;
    r.frame_width = wid_acc;
    r.frame_height = hgt_acc;
  endtask

  task automatic deframe_step(input logic op, input logic [7:0] b,
                              output bit got_result, output result_t r);
    logic last;
    got_result = 1'b0;
    r = '0;
    if (op == OP_RECONNECT) begin
      if (dphase == IN_PAYLOAD) begin
        make_result(ST_ABORT, 8'h00, 1'b0, r);
        got_result = 1'b1;
      end
      restart_search();
    end else if (dphase == DROPPING) begin
      // ignored until reconnect
    end else if (dphase == IN_PAYLOAD) begin
      last = (remaining <= 25'd1);
      make_result(ST_DATA, b, last, r);
      got_result = 1'b1;
      if (last) restart_search();
      else remaining = remaining - 25'd1;
    end else begin
      case (hdr_count)
        3'd0: len_acc[7:0] = b;
        3'd1: len_acc[15:8] = b;
        3'd2: len_acc[23:16] = b;
        3'd3: len_acc[31:24] = b;
        3'd4: wid_acc[7:0] = b;
        3'd5: wid_acc[15:8] = b;
        3'd6: hgt_acc[7:0] = b;
        default: hgt_acc[15:8] = b;
      endcase
      if (hdr_count != 3'd7) begin
        hdr_count = hdr_count + 3'd1;
      end else begin
        hdr_count = '0;
        // length is checked ahead of the dimensions
        if (len_acc == 32'd0 || len_acc > {7'd0, limits.max_payload_len}) begin
          make_result(ST_BAD_LEN, 8'h00, 1'b0, r);
          got_result = 1'b1;
          dphase = DROPPING;
        end else if (wid_acc == 16'd0 || hgt_acc == 16'd0 ||
                     wid_acc > limits.max_width || hgt_acc > limits.max_height) begin
          make_result(ST_BAD_DIM, 8'h00, 1'b0, r);
          got_result = 1'b1;
          dphase = DROPPING;
        end else begin
          remaining = len_acc[24:0];
          dphase = IN_PAYLOAD;
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("cycle %0d: %s mismatch, got %0h expected %0h", cycle, what, got, want);
    mismatch_count++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_MAX_LEN: limits.max_payload_len = value;
      REG_MAX_WIDTH: limits.max_width = value[DIM_W-1:0];
      REG_MAX_HEIGHT: limits.max_height = value[DIM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_limits(input logic [CFG_W-1:0] max_len, input logic [15:0] max_w,
                            input logic [15:0] max_h);
    write_reg(REG_MAX_LEN, max_len);
    write_reg(REG_MAX_WIDTH, {9'd0, max_w});
    write_reg(REG_MAX_HEIGHT, {9'd0, max_h});
  endtask

  task automatic add_item(input logic op, input logic [7:0] b);
    stream_item_t it;
    it.op = op;
    it.data = b;
    pending_items.push_back(it);
  endtask

  task automatic add_header(input logic [31:0] len, input logic [15:0] w, input logic [15:0] h);
    for (int i = 0; i < 4; i++) add_item(OP_BYTE, len[8*i +: 8]);
    add_item(OP_BYTE, w[7:0]);
    add_item(OP_BYTE, w[15:8]);
    add_item(OP_BYTE, h[7:0]);
    add_item(OP_BYTE, h[15:8]);
  endtask

  task automatic add_payload(input int n);
    for (int i = 0; i < n; i++) add_item(OP_BYTE, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [15:0] good_dim(input logic [15:0] lim);
    int r;
    r = $urandom_range(0, 9);
    if (lim == 16'd0) return 16'($urandom_range(1, 65535));
    if (r == 0) return 16'd1;
    if (r == 1) return lim;
    return 16'($urandom_range(1, lim));
  endfunction

  function automatic logic [15:0] bad_dim(input logic [15:0] lim);
    if (lim == 16'hFFFF || $urandom_range(0, 2) == 0) return 16'd0;
    return 16'($urandom_range(32'(lim) + 32'd1, 65535));
  endfunction

  function automatic logic [31:0] good_len();
    int unsigned lmax;
    lmax = (limits.max_payload_len < 12) ? limits.max_payload_len : 12;
    if (lmax == 0) return 32'd1;
    if (limits.max_payload_len <= 64 && $urandom_range(0, 7) == 0)
      return 32'(limits.max_payload_len);
    return $urandom_range(1, lmax);
  endfunction

  // Drop a few bytes after a rejected header, then reconnect.
  task automatic add_drop_tail(inout int ignored);
    int n;
    n = $urandom_range(0, 3);
    add_payload(n);
    ignored += n;
    add_item(OP_RECONNECT, 8'($urandom_range(0, 255)));
  endtask

  task automatic add_random_phase(input int target);
    int base;
    int ignored;
    int kind;
    int n;
    logic [31:0] len;
    logic [31:0] v;
    logic [15:0] w;
    logic [15:0] h;
    base = pending_items.size();
    ignored = 0;
    while (pending_items.size() - base - ignored < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        len = good_len();
        add_header(len, good_dim(limits.max_width), good_dim(limits.max_height));
        add_payload(int'(len));
      end else if (kind < 63) begin
        // long frame cut short by a reconnect
        len = (limits.max_payload_len >= 2) ? $urandom_range(2, limits.max_payload_len) : 1;
        add_header(len, good_dim(limits.max_width), good_dim(limits.max_height));
        n = $urandom_range(0, 5);
        add_payload(int'((n < len) ? 32'(n) : len - 32'd1));
        add_item(OP_RECONNECT, 8'($urandom_range(0, 255)));
      end else if (kind < 73) begin
        n = $urandom_range(0, 2);
        if (n == 0) len = 32'd0;
        else if (n == 1) len = limits.max_payload_len + 1;
        else begin
          v = $urandom;
          len = (v > limits.max_payload_len) ? v : (v | 32'h8000_0000);
        end
        add_header(len, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        add_drop_tail(ignored);
      end else if (kind < 83) begin
        w = good_dim(limits.max_width);
        h = good_dim(limits.max_height);
        n = $urandom_range(0, 2);
        if (n == 0) w = bad_dim(limits.max_width);
        else if (n == 1) h = bad_dim(limits.max_height);
        else begin
          w = bad_dim(limits.max_width);
          h = bad_dim(limits.max_height);
        end
        add_header(good_len(), w, h);
        add_drop_tail(ignored);
      end else if (kind < 91) begin
        add_payload($urandom_range(1, 7));
        add_item(OP_RECONNECT, 8'($urandom_range(0, 255)));
      end else begin
        add_item(OP_RECONNECT, 8'($urandom_range(0, 255)));
        n = $urandom_range(1, 7);
        for (int i = 0; i < n; i++)
          add_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        add_item(OP_RECONNECT, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // driver: present the head of the pending list, with random gaps
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (pending_items.size() != 0 && !idle_now()) begin
      push <= 1'b1;
      operation <= pending_items[0].op;
      stream_byte <= pending_items[0].data;
    end else begin
      push <= 1'b0;
    end
  end

  always @(negedge clk) begin
    pop <= !rst && !idle_now();
  end

  // accepted input transaction: run the predictor
  always @(posedge clk) begin
    if (!rst && push && !full) begin
      void'(pending_items.pop_front());
      deframe_step(operation, stream_byte, produced, predicted);
      if (produced) expected_results.push_back(predicted);
    end
  end

  // monitor: check each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, status", 32'(status), 32'd0);
      end else begin
        oldest = expected_results.pop_front();
        if (status !== oldest.status)
          report_mismatch("status", 32'(status), 32'(oldest.status));
        if (payload_byte !== oldest.payload_byte)
          report_mismatch("payload_byte", 32'(payload_byte), 32'(oldest.payload_byte));
        if (is_last !== oldest.is_last)
          report_mismatch("is_last", 32'(is_last), 32'(oldest.is_last));
        if (frame_width !== oldest.frame_width)
          report_mismatch("frame_width", 32'(frame_width), 32'(oldest.frame_width));
        if (frame_height !== oldest.frame_height)
          report_mismatch("frame_height", 32'(frame_height), 32'(oldest.frame_height));
      end
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    limits.max_payload_len = MAX_LEN_RST;
    limits.max_width = MAX_WIDTH_RST;
    limits.max_height = MAX_HEIGHT_RST;
    restart_search();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, at the reset limits
    add_item(OP_RECONNECT, 8'h00);                      // reconnect while idle
    add_header(32'd0, 16'd0, 16'd0);                    // bad length wins over bad dims
    add_item(OP_BYTE, 8'hFF);                           // dropped
    add_item(OP_RECONNECT, 8'hFF);
    add_header(32'd2, MAX_WIDTH_RST, MAX_HEIGHT_RST);   // dims exactly at the limits
    add_item(OP_BYTE, 8'hA5);
    add_item(OP_RECONNECT, 8'h00);                      // abort mid-payload
    add_item(OP_BYTE, 8'h01);
    add_item(OP_BYTE, 8'h00);
    add_item(OP_RECONNECT, 8'h00);                      // partial header discarded
    add_random_phase(PHASE_ITEMS);
    wait_idle();

    set_limits(25'($urandom_range(1, 16)), 16'($urandom_range(1, 300)),
               16'($urandom_range(1, 300)));
    add_random_phase(PHASE_ITEMS);
    wait_idle();

    // widest dimension limits at the reset length limit, no gaps on either side
    set_limits(25'd16777216, 16'hFFFF, 16'hFFFF);
    no_idle = 1'b1;
    add_random_phase(PHASE_ITEMS);
    wait_idle();
    no_idle = 1'b0;

    set_limits(25'd1, 16'd1, 16'd1);
    add_random_phase(PHASE_ITEMS);
    wait_idle();

    // zero width limit rejects every header that gets past the length check
    set_limits(25'd8, 16'd0, 16'd100);
    add_random_phase(PHASE_ITEMS);
    wait_idle();

    set_limits(25'($urandom_range(1, 16777216)), 16'($urandom_range(1, 65535)),
               16'($urandom_range(1, 65535)));
    add_random_phase(PHASE_ITEMS);
    wait_idle();

    set_limits(MAX_LEN_RST, MAX_WIDTH_RST, MAX_HEIGHT_RST);
    add_random_phase(PHASE_ITEMS);
    wait_idle();

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
